>>> rtl/mandelbrot_period_detector_top_assert.svh
// assertion macros for the mandelbrot period detector
// expects clk_i and rst_ni in the scope where the macros are used
`ifndef MANDELBROT_PERIOD_DETECTOR_TOP_ASSERT_SVH
`define MANDELBROT_PERIOD_DETECTOR_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MPD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mpd assertion failed");

// next-cycle implication, checked out of reset
`define MPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mpd assertion failed");

`endif

>>> rtl/mpd_pkg.sv
// shared constants and fixed-point helpers for the mandelbrot period detector
// no dependencies
package mpd_pkg;

  localparam int unsigned CntW = 13;
  localparam logic [63:0] Sign64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] Smax64 = 64'h7FFF_FFFF_FFFF_FFFF;

  // point class codes
  localparam logic [1:0] ClsEscaped  = 2'd0;
  localparam logic [1:0] ClsPeriodic = 2'd1;
  localparam logic [1:0] ClsBounded  = 2'd2;

  // register indexes
  localparam logic [2:0] RegIterLimit = 3'd0;
  localparam logic [2:0] RegEscapeSq  = 3'd1;
  localparam logic [2:0] RegPeriodTol = 3'd2;
  localparam logic [2:0] RegStableTol = 3'd3;

  // magnitude of a signed value
  function automatic logic [63:0] mag(logic [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  // signed add saturated to the 64-bit range
  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) begin
      r = a[63] ? Sign64 : Smax64;
    end
    return r;
  endfunction

  // cap an unsigned value at 2^63-1
  function automatic logic [63:0] cap63(logic [63:0] s);
    return s[63] ? Smax64 : s;
  endfunction

  // unsigned add of two capped values, capped
  function automatic logic [63:0] ucap_add(logic [63:0] a, logic [63:0] b);
    return cap63(a + b);
  endfunction

  // exact magnitude of a - b for signed a and b
  function automatic logic [63:0] diff_mag(logic [63:0] a, logic [63:0] b);
    return ({~a[63], a[62:0]} >= {~b[63], b[62:0]}) ? (a - b) : (b - a);
  endfunction

endpackage

>>> rtl/mandelbrot_period_detector_top.sv
// mandelbrot escape-time engine with period and stability search
// depends on mpd_pkg and mandelbrot_period_detector_top_assert.svh
//
// channel  dir  handshake              payload
// in       in   in_valid_i/in_ready_o   c_real_i, c_imag_i
// out      out  out_valid_o/out_ready_i point_class_o, period_o, stable_span_o,
//                                       escape_count_o
// cfg      in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// one shared 32x32 multiplier builds each 64x64 product
// reset clears control and loads register defaults; the history needs no clearing
// a finished result waits in the output register while the next item is taken
module mandelbrot_period_detector_top
  import mpd_pkg::*;
#(
  parameter int unsigned MAX_ITER  = 4096,
  parameter int unsigned FRAC_BITS = 60
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [63:0] c_real_i,
  input  logic signed [63:0] c_imag_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         point_class_o,
  output logic [11:0]        period_o,
  output logic [12:0]        stable_span_o,
  output logic [12:0]        escape_count_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  localparam int unsigned AddrW = (MAX_ITER > 1) ? $clog2(MAX_ITER) : 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, IT_CHK, IT_SR, IT_SI, IT_UPD,
    PS_INIT, SR_RD, SR_DIF, SR_SQ1, SR_SQ2, SS_CHK, ST_DONE
  } state_e;

  // configuration registers
  logic [CntW-1:0] iter_limit_q;
  logic [62:0]     esc_lim_q, per_tol_q, stab_tol_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_limit_q <= 13'd4096;
      esc_lim_q    <= 63'd4611686018427387904;
      per_tol_q    <= 63'd11529215046;
      stab_tol_q   <= 63'd1152922;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegIterLimit: iter_limit_q <= cfg_data_i[CntW-1:0];
        RegEscapeSq:  esc_lim_q    <= cfg_data_i[62:0];
        RegPeriodTol: per_tol_q    <= cfg_data_i[62:0];
        RegStableTol: stab_tol_q   <= cfg_data_i[62:0];
        default: ;
      endcase
    end
  end

  // control and datapath registers
  state_e          state_q, ret_q;
  logic            stab_q;
  logic [CntW-1:0] lim_q, cnt_q, p_q, s_q;
  logic [63:0]     cr_q, ci_q, zr_q, zi_q, sr_q, si_q, d1_q, di_q;
  logic [63:0]     mul_a_q, mul_b_q;
  logic [127:0]    acc_q;
  logic [1:0]      mul_step_q;
  logic [1:0]      cls_q;
  logic [CntW-1:0] per_q, span_q, esc_q;
  logic            out_valid_q;
  logic [1:0]      point_class_q;
  logic [11:0]     period_q;
  logic [12:0]     stable_span_q, escape_count_q;

  // orbit history: one write port, two registered read ports
  logic [127:0]    hist_mem [MAX_ITER];
  logic [127:0]    rda_q, rdb_q;
  logic            wr_en;
  logic [AddrW-1:0] wr_addr, rda_addr, rdb_addr;
  logic [127:0]    wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_mem[wr_addr] <= wr_data;
    end
    rda_q <= hist_mem[rda_addr];
    rdb_q <= hist_mem[rdb_addr];
  end

  // partial product of the shared multiplier
  logic [31:0]  pa, pb;
  logic [63:0]  part;
  logic [127:0] part_sh;

  always_comb begin
    pa = mul_step_q[1] ? mul_a_q[63:32] : mul_a_q[31:0];
    pb = mul_step_q[0] ? mul_b_q[63:32] : mul_b_q[31:0];
    part = 64'(pa) * 64'(pb);
    case (mul_step_q)
      2'd0:    part_sh = {64'd0, part};
      2'd3:    part_sh = {part, 64'd0};
      default: part_sh = {32'd0, part, 32'd0};
    endcase
  end

  // shifted and saturated product forms
  logic [127:0] sh_f, sh_f1;
  logic [63:0]  usq_v, um_f1, smul_v;

  always_comb begin
    sh_f  = acc_q >> FRAC_BITS;
    sh_f1 = acc_q >> (FRAC_BITS - 1);
    usq_v = cap63((|sh_f[127:64]) ? '1 : sh_f[63:0]);
    um_f1 = (|sh_f1[127:64]) ? '1 : sh_f1[63:0];
    if (zr_q[63] ^ zi_q[63]) begin
      smul_v = um_f1[63] ? Sign64 : (64'd0 - um_f1);
    end else begin
      smul_v = um_f1[63] ? Smax64 : um_f1;
    end
  end

  // iteration update and search helpers
  logic [63:0]     nr, ni, esc_sum, gap_sq;
  logic [63:0]     cmp_re, cmp_im;
  logic [CntW-1:0] lim_in, p_nxt;

  always_comb begin
    nr      = sat_add(sr_q - si_q, cr_q);
    ni      = sat_add(smul_v, ci_q);
    esc_sum = ucap_add(sr_q, usq_v);
    gap_sq  = ucap_add(d1_q, usq_v);
    cmp_re  = stab_q ? rda_q[127:64] : zr_q;
    cmp_im  = stab_q ? rda_q[63:0]   : zi_q;
    lim_in  = (32'(iter_limit_q) > MAX_ITER) ? CntW'(MAX_ITER) : iter_limit_q;
    p_nxt   = p_q + 1'b1;
    wr_en   = (state_q == IT_UPD);
    wr_addr = AddrW'(cnt_q);
    wr_data = {nr, ni};
    rda_addr = AddrW'(lim_q - 1'b1 - s_q);
    rdb_addr = stab_q ? AddrW'(lim_q - 1'b1 - p_q - s_q) : AddrW'(lim_q - 1'b1 - p_q);
  end

  // main sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      out_valid_q <= 1'b0;
      mul_step_q  <= '0;
      stab_q      <= 1'b0;
    end else begin
      // result taken, unless a new one replaces it this cycle
      if (out_valid_q && out_ready_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            cr_q    <= c_real_i;
            ci_q    <= c_imag_i;
            zr_q    <= '0;
            zi_q    <= '0;
            cnt_q   <= '0;
            lim_q   <= lim_in;
            cls_q   <= ClsBounded;
            per_q   <= '0;
            span_q  <= '0;
            esc_q   <= '0;
            state_q <= IT_CHK;
          end
        end
        ST_MUL: begin
          acc_q      <= acc_q + part_sh;
          mul_step_q <= mul_step_q + 1'b1;
          if (mul_step_q == 2'd3) begin
            state_q <= ret_q;
          end
        end
        IT_CHK: begin
          if (cnt_q == lim_q) begin
            state_q <= PS_INIT;
          end else begin
            mul_a_q <= mag(zr_q);
            mul_b_q <= mag(zr_q);
            acc_q   <= '0;
            ret_q   <= IT_SR;
            state_q <= ST_MUL;
          end
        end
        IT_SR: begin
          sr_q    <= usq_v;
          mul_a_q <= mag(zi_q);
          mul_b_q <= mag(zi_q);
          acc_q   <= '0;
          ret_q   <= IT_SI;
          state_q <= ST_MUL;
        end
        IT_SI: begin
          if (esc_sum >= {1'b0, esc_lim_q}) begin
            cls_q   <= ClsEscaped;
            esc_q   <= cnt_q;
            state_q <= ST_DONE;
          end else begin
            si_q    <= usq_v;
            mul_a_q <= mag(zr_q);
            mul_b_q <= mag(zi_q);
            acc_q   <= '0;
            ret_q   <= IT_UPD;
            state_q <= ST_MUL;
          end
        end
        IT_UPD: begin
          zr_q    <= nr;
          zi_q    <= ni;
          cnt_q   <= cnt_q + 1'b1;
          state_q <= IT_CHK;
        end
        PS_INIT: begin
          p_q    <= 13'd1;
          s_q    <= '0;
          stab_q <= 1'b0;
          if ((14'd3) < {1'b0, lim_q}) begin
            state_q <= SR_RD;
          end else begin
            state_q <= ST_DONE;
          end
        end
        SR_RD: begin
          state_q <= SR_DIF;
        end
        SR_DIF: begin
          mul_a_q <= diff_mag(cmp_re, rdb_q[127:64]);
          mul_b_q <= diff_mag(cmp_re, rdb_q[127:64]);
          di_q    <= diff_mag(cmp_im, rdb_q[63:0]);
          acc_q   <= '0;
          ret_q   <= SR_SQ1;
          state_q <= ST_MUL;
        end
        SR_SQ1: begin
          d1_q    <= usq_v;
          mul_a_q <= di_q;
          mul_b_q <= di_q;
          acc_q   <= '0;
          ret_q   <= SR_SQ2;
          state_q <= ST_MUL;
        end
        SR_SQ2: begin
          if (stab_q) begin
            // stability walk: first break from the shifted orbit
            if (gap_sq > {1'b0, stab_tol_q}) begin
              span_q  <= lim_q - s_q;
              state_q <= ST_DONE;
            end else begin
              s_q     <= s_q + 1'b1;
              state_q <= SS_CHK;
            end
          end else if (gap_sq < {1'b0, per_tol_q}) begin
            // period found, start the stability walk
            cls_q   <= ClsPeriodic;
            per_q   <= p_q;
            stab_q  <= 1'b1;
            state_q <= SS_CHK;
          end else begin
            p_q <= p_nxt;
            if (({1'b0, p_nxt} + 14'd2) < {1'b0, lim_q}) begin
              state_q <= SR_RD;
            end else begin
              state_q <= ST_DONE;
            end
          end
        end
        SS_CHK: begin
          if (s_q < lim_q - p_q) begin
            state_q <= SR_RD;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q    <= 1'b1;
            point_class_q  <= cls_q;
            period_q       <= per_q[11:0];
            stable_span_q  <= span_q;
            escape_count_q <= esc_q;
            state_q        <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign point_class_o  = point_class_q;
  assign period_o       = period_q;
  assign stable_span_o  = stable_span_q;
  assign escape_count_o = escape_count_q;

  // checks
  `include "mandelbrot_period_detector_top_assert.svh"
  `MPD_ASSERT_NEXT(a_busy_after_take, in_valid_i && in_ready_o, !in_ready_o)
  `MPD_ASSERT_NOW(a_hist_write_in_range, wr_en, cnt_q < lim_q)
  `MPD_ASSERT_NOW(a_escaped_clean, out_valid_o && point_class_o == ClsEscaped,
                  period_o == 12'd0 && stable_span_o == 13'd0)
  `MPD_ASSERT_NOW(a_bounded_clean, out_valid_o && point_class_o == ClsBounded,
                  period_o == 12'd0 && escape_count_o == 13'd0)

endmodule

>>> verif/tb.sv
// self-checking testbench for mandelbrot_period_detector_top
// depends on mpd_pkg and the top-level rtl; predicts every point in fixed point
`timescale 1ns / 1ps

module tb;
  import mpd_pkg::*;

  localparam int unsigned Depth    = 4096;
  localparam int unsigned Frac     = 60;
  localparam int unsigned CycLimit = 20000000;
  localparam logic [63:0] One      = 64'h1000_0000_0000_0000;

  typedef struct packed {
    logic [63:0] re;
    logic [63:0] im;
  } point_t;

  typedef struct packed {
    logic [1:0]  cls;
    logic [11:0] per;
    logic [12:0] span;
    logic [12:0] esc;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready_o;
  logic signed [63:0] c_re = '0;
  logic signed [63:0] c_im = '0;
  logic               out_valid_o;
  logic               out_rdy = 1'b0;
  logic [1:0]         point_class_o;
  logic [11:0]        period_o;
  logic [12:0]        stable_span_o;
  logic [12:0]        escape_count_o;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_idx = '0;
  logic [63:0]        cfg_data = '0;

  // shadow registers of the block
  logic [12:0] lim_reg;
  logic [63:0] esc_sq_reg;
  logic [63:0] per_tol_reg;
  logic [63:0] stab_tol_reg;

  logic [63:0] orb_re [Depth];
  logic [63:0] orb_im [Depth];

  point_t   pending_pts[$];
  verdict_t expected_verdicts[$];

  int  errors = 0;
  int  cycles = 0;
  bit  calm = 1'b0;
  bit  hold_arm = 1'b0;
  bit  hold_used = 1'b0;
  int  hold_left = 0;

  mandelbrot_period_detector_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .c_real_i      (c_re),
    .c_imag_i      (c_im),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_rdy),
    .point_class_o (point_class_o),
    .period_o      (period_o),
    .stable_span_o (stable_span_o),
    .escape_count_o(escape_count_o),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  // fixed-point arithmetic of the orbit
  function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> sh;
    if (p[127:64] != '0) return '1;
    return p[63:0];
  endfunction

  function automatic logic [63:0] absval(logic [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  function automatic logic [63:0] smul_shr(logic [63:0] a, logic [63:0] b, int sh);
    logic [63:0] m;
    m = mul_shr(absval(a), absval(b), sh);
    if (a[63] ^ b[63]) return (m >= Sign64) ? Sign64 : (64'd0 - m);
    return (m > Smax64) ? Smax64 : m;
  endfunction

  function automatic logic [63:0] add_clip(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) r = a[63] ? Sign64 : Smax64;
    return r;
  endfunction

  function automatic logic [63:0] square_of(logic [63:0] m);
    logic [63:0] s;
    s = mul_shr(m, m, Frac);
    return (s > Smax64) ? Smax64 : s;
  endfunction

  function automatic logic [63:0] norm_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] r;
    r = {1'b0, a} + {1'b0, b};
    return (r > {1'b0, Smax64}) ? Smax64 : r[63:0];
  endfunction

  function automatic logic [63:0] gap_sq(logic [63:0] ar, logic [63:0] ai,
                                         logic [63:0] br, logic [63:0] bi);
    logic [63:0] dr, di;
    dr = ($signed(ar) >= $signed(br)) ? (ar - br) : (br - ar);
    di = ($signed(ai) >= $signed(bi)) ? (ai - bi) : (bi - ai);
    return norm_add(square_of(dr), square_of(di));
  endfunction

  // escape time, then period and stability search over the orbit
  function automatic verdict_t classify_point(point_t c);
    verdict_t v;
    int lim, cnt, a, b;
    logic [63:0] zr, zi, nr, ni;
    v = '{cls: ClsBounded, per: '0, span: '0, esc: '0};
    lim = (lim_reg > Depth) ? Depth : lim_reg;
    cnt = 0;
    zr = '0;
    zi = '0;
    while (cnt < lim &&
           norm_add(square_of(absval(zr)), square_of(absval(zi))) < esc_sq_reg) begin
      nr = add_clip(square_of(absval(zr)) - square_of(absval(zi)), c.re);
      ni = add_clip(smul_shr(zr, zi, Frac - 1), c.im);
      zr = nr;
      zi = ni;
      orb_re[cnt] = nr;
      orb_im[cnt] = ni;
      cnt++;
    end
    if (cnt == lim) begin
      for (int p = 1; p < lim - 2; p++) begin
        if (gap_sq(zr, zi, orb_re[lim-1-p], orb_im[lim-1-p]) < per_tol_reg) begin
          v.cls = ClsPeriodic;
          v.per = p[11:0];
          for (int s = 0; s < lim - p; s++) begin
            a = lim - 1 - s;
            b = lim - 1 - p - s;
            if (gap_sq(orb_re[a], orb_im[a], orb_re[b], orb_im[b]) > stab_tol_reg) begin
              v.span = 13'(lim - s);
              break;
            end
          end
          break;
        end
      end
    end else begin
      v.cls = ClsEscaped;
      v.esc = 13'(cnt);
    end
    return v;
  endfunction

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // input driver: offers queued points, predicts on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        expected_verdicts.push_back(classify_point('{re: c_re, im: c_im}));
      end
      if (!in_valid || in_ready_o) begin
        if (pending_pts.size() > 0 && (calm || $urandom_range(0, 99) >= 32)) begin
          point_t nxt;
          nxt = pending_pts.pop_front();
          c_re <= nxt.re;
          c_im <= nxt.im;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_rdy <= 1'b0;
    end else begin
      if (out_valid_o && out_rdy) begin
        if (expected_verdicts.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result item class %0d", point_class_o);
        end else begin
          verdict_t e;
          e = expected_verdicts.pop_front();
          if (e.cls !== point_class_o || e.per !== period_o ||
              e.span !== stable_span_o || e.esc !== escape_count_o) begin
            errors++;
            if (errors <= 10)
              $display("mismatch cls %0d/%0d per %0d/%0d span %0d/%0d esc %0d/%0d",
                       e.cls, point_class_o, e.per, period_o,
                       e.span, stable_span_o, e.esc, escape_count_o);
          end
        end
      end
      if (hold_arm && !hold_used) begin
        hold_used <= 1'b1;
        hold_left <= 3000;
        out_rdy <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_rdy <= 1'b0;
      end else begin
        out_rdy <= calm || ($urandom_range(0, 99) >= 32);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      RegIterLimit: lim_reg = data[12:0];
      RegEscapeSq:  esc_sq_reg = {1'b0, data[62:0]};
      RegPeriodTol: per_tol_reg = {1'b0, data[62:0]};
      RegStableTol: stab_tol_reg = {1'b0, data[62:0]};
      default: ;
    endcase
  endtask

  // sample on the falling edge so the driver's updates have settled
  task automatic drain();
    while (pending_pts.size() > 0 || in_valid || expected_verdicts.size() > 0)
      @(negedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // mostly points near the set and near known cycles, some raw noise
  function automatic point_t rand_point();
    point_t c;
    logic [63:0] noise;
    int mode;
    mode = $urandom_range(0, 9);
    noise = {{24{$urandom_range(0, 1) == 1}}, 40'($urandom()) << 8};
    case (mode)
      0, 1: c = '{re: rand64(), im: rand64()};
      2: c = '{re: (64'd0 - One) + noise, im: noise};
      3: c = '{re: (64'd0 - (One >> 3)) + noise, im: ((One >> 2) * 3) + noise};
      4: c = '{re: (64'd0 - (One >> 2)) + noise, im: noise};
      default: begin
        c.re = {{3{$urandom_range(0, 1) == 1}}, 61'(rand64())};
        c.im = {{3{$urandom_range(0, 1) == 1}}, 61'(rand64())};
      end
    endcase
    return c;
  endfunction

  function automatic point_t far_point();
    bit sr, si;
    sr = $urandom_range(0, 1);
    si = $urandom_range(0, 1);
    return '{re: {sr, ~sr, 62'(rand64())}, im: {si, 63'(rand64())}};
  endfunction

  // stimulus sequence
  initial begin
    lim_reg = 13'd4096;
    esc_sq_reg = 64'd4611686018427387904;
    per_tol_reg = 64'd11529215046;
    stab_tol_reg = 64'd1152922;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: fixed points, a periodic orbit, escape at the edge, extremes
    pending_pts.push_back('{re: 64'd0, im: 64'd0});
    pending_pts.push_back('{re: 64'd0 - One, im: 64'd0});
    pending_pts.push_back('{re: One << 1, im: 64'd0});
    pending_pts.push_back('{re: 64'd0 - (One << 1), im: 64'd0});
    pending_pts.push_back('{re: Smax64, im: Smax64});
    pending_pts.push_back('{re: Sign64, im: Sign64});
    pending_pts.push_back('{re: Smax64, im: 64'd0});
    pending_pts.push_back('{re: 64'd0, im: Sign64});
    pending_pts.push_back('{re: One, im: One});
    drain();

    // zero limit and ignored register indexes
    write_reg(RegIterLimit, 64'd0);
    write_reg(3'd4, rand64());
    write_reg(3'd7, rand64());
    pending_pts.push_back('{re: 64'd0, im: 64'd0});
    pending_pts.push_back('{re: Smax64, im: Sign64});
    drain();

    // smallest limit that runs the period search, zero escape radius and zero tolerances
    write_reg(RegIterLimit, 64'd4);
    write_reg(RegEscapeSq, 64'd0);
    write_reg(RegPeriodTol, 64'd0);
    write_reg(RegStableTol, 64'd0);
    repeat (4) pending_pts.push_back(rand_point());
    drain();

    // limit above depth, widest radius and tolerances, far points only
    write_reg(RegIterLimit, 64'h1FFF);
    write_reg(RegEscapeSq, '1);
    write_reg(RegPeriodTol, '1);
    write_reg(RegStableTol, '1);
    repeat (6) pending_pts.push_back(far_point());
    drain();

    // random points with a long receiver hold-off
    write_reg(RegIterLimit, 64'd24);
    write_reg(RegEscapeSq, One << 2);
    write_reg(RegPeriodTol, 64'd1 << 40);
    write_reg(RegStableTol, 64'd1 << 20);
    repeat (35) pending_pts.push_back(rand_point());
    hold_arm = 1'b1;
    drain();

    // loose tolerances, no idling on either side
    write_reg(RegIterLimit, 64'd12);
    write_reg(RegPeriodTol, 64'd1 << 56);
    write_reg(RegStableTol, 64'd1 << 50);
    calm = 1'b1;
    repeat (30) pending_pts.push_back(rand_point());
    drain();
    calm = 1'b0;

    // longer orbits with reset-value tolerances
    write_reg(RegIterLimit, 64'd40);
    write_reg(RegPeriodTol, 64'd11529215046);
    write_reg(RegStableTol, 64'd1152922);
    repeat (30) pending_pts.push_back(rand_point());
    drain();

    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
